@@ hw/rtl/hsv2argb_pkg.sv @@
// hsv2argb_pkg: shared types, constants and the channel scaling function
// for the hsv to argb pixel core and its testbench
// depends on nothing
`default_nettype none

package hsv2argb_pkg;

   // one 60 degree sector in 1/16 degree units
   localparam logic [9:0]  SECTOR_SPAN   = 10'd960;
   localparam logic [2:0]  SECTOR_COUNT  = 3'd6;
   // floor(2^26 / 960), quotient estimate for the hue sector index
   localparam logic [16:0] HUE_RECIP     = 17'd69905;
   // 2^8 / 6 rounded up, exact for small sector indexes
   localparam logic [5:0]  SECTOR_RECIP  = 6'd43;
   // floor(2^38 / 960), quotient estimate for the secondary component
   localparam logic [28:0] X_RECIP       = 29'd286331153;
   localparam logic [7:0]  BYTE_MAX      = 8'd255;

   typedef enum logic [2:0] {
      SECTOR_RED_YELLOW,
      SECTOR_YELLOW_GREEN,
      SECTOR_GREEN_CYAN,
      SECTOR_CYAN_BLUE,
      SECTOR_BLUE_MAGENTA,
      SECTOR_MAGENTA_RED
   } sector_type;

   typedef enum logic [0:0] {
      BYTE_ORDER_ARGB,
      BYTE_ORDER_RGBA
   } byte_order_type;

   // 1/65536 fraction to an 8-bit channel, truncating and clamping
   function automatic logic [7:0] to_byte(input logic signed [20:0] level);
      logic [19:0] mag;
      logic [28:0] scaled;
      logic [12:0] quo;
      logic [7:0]  res;
      begin
         mag    = level[19:0];
         scaled = {mag, 8'd0} - {9'd0, mag};
         quo    = scaled[28:16];
         if (level <= 21'sd0) begin
            res = 8'd0;
         end else if (quo > 13'(BYTE_MAX)) begin
            res = BYTE_MAX;
         end else begin
            res = quo[7:0];
         end
         return res;
      end
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/hsv_to_argb_pixel_core.sv @@
// hsv_to_argb_pixel_core: six-stage pipelined hsv plus alpha to packed pixel
// converter with a byte order register
// depends on hsv2argb_pkg
`default_nettype none

// Takes one transaction per clock while the result channel does not stall and
// returns its packed pixel from the output register, one pixel per clock under
// the same condition. The six register stages are: hue quotient estimate and
// chroma product, sector correction and offset, chroma times sector position,
// reciprocal estimate of the secondary component, its correction, and the
// channel scaling with packing into the output register. A stall on the
// result side holds the whole pipeline; csr writes are always accepted and
// take effect on pixels entering the output register.

module hsv_to_argb_pixel_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [15:0] req_hue_sixteenths,
   input  wire logic [8:0]  req_saturation,
   input  wire logic [8:0]  req_brightness,
   input  wire logic [8:0]  req_opacity,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_packed_pixel,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [0:0]  csr_byte_order
);

   logic advance;
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   hsv2argb_pkg::byte_order_type byte_order_ff;

   // stage 1
   logic [32:0] hue_prod_in;
   logic [15:0] hue1_ff;
   logic [6:0]  kest1_ff;
   logic [17:0] c1_ff, c1_in;
   logic [8:0]  val1_ff, alp1_ff;

   // stage 2
   logic [16:0] rem2;
   logic        fix2;
   logic [16:0] alp_scaled2;
   logic [6:0]  k2_ff, k2_in;
   logic [9:0]  f2_ff, f2_in;
   logic [17:0] c2_ff;
   logic signed [19:0] m2_ff, m2_in;
   logic [7:0]  ab2_ff, ab2_in;

   // stage 3
   logic [12:0] k43;
   logic [4:0]  q6;
   logic [6:0]  sec_raw3;
   logic [10:0] t3;
   hsv2argb_pkg::sector_type sector3_ff, sector3_in;
   logic [28:0] ct3_ff, ct3_in;
   logic [17:0] c3_ff;
   logic signed [19:0] m3_ff;
   logic [7:0]  ab3_ff;

   // stage 4
   logic [57:0] x_prod4;
   hsv2argb_pkg::sector_type sector4_ff;
   logic [28:0] ct4_ff;
   logic [17:0] xq4_ff, xq4_in;
   logic [17:0] c4_ff;
   logic signed [19:0] m4_ff;
   logic [7:0]  ab4_ff;

   // stage 5
   logic [28:0] xr5;
   hsv2argb_pkg::sector_type sector5_ff;
   logic [17:0] x5_ff, x5_in;
   logic [17:0] c5_ff;
   logic signed [19:0] m5_ff;
   logic [7:0]  ab5_ff;

   // stage 6
   logic signed [20:0] cs6, xs6, ms6;
   logic signed [20:0] red6, green6, blue6;
   logic [7:0]  rb6, gb6, bb6;
   logic [31:0] pixel6_ff, pixel6_in;

   assign advance   = !v6_ff || rsp_ready;
   assign req_ready = advance;
   assign csr_ready = 1'b1;
   assign rsp_valid = v6_ff;
   assign rsp_packed_pixel = pixel6_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         byte_order_ff <= hsv2argb_pkg::BYTE_ORDER_ARGB;
      end else begin
         if (advance) begin
            v1_ff <= req_valid;
            v2_ff <= v1_ff;
            v3_ff <= v2_ff;
            v4_ff <= v3_ff;
            v5_ff <= v4_ff;
            v6_ff <= v5_ff;
         end
         if (csr_valid) begin
            byte_order_ff <= hsv2argb_pkg::byte_order_type'(csr_byte_order);
         end
      end
   end

   always_comb begin
      hue_prod_in = 33'(req_hue_sixteenths) * 33'(hsv2argb_pkg::HUE_RECIP);
      c1_in       = 18'(req_saturation) * 18'(req_brightness);
   end

   always_comb begin
      rem2  = {1'b0, hue1_ff} - 17'(kest1_ff) * 17'(hsv2argb_pkg::SECTOR_SPAN);
      fix2  = rem2 >= 17'(hsv2argb_pkg::SECTOR_SPAN);
      k2_in = kest1_ff + 7'(fix2);
      f2_in = fix2 ? 10'(rem2 - 17'(hsv2argb_pkg::SECTOR_SPAN)) : rem2[9:0];
      m2_in = $signed({3'd0, val1_ff, 8'd0}) - $signed({2'd0, c1_ff});
      alp_scaled2 = {alp1_ff, 8'd0} - {8'd0, alp1_ff};
      ab2_in = (alp_scaled2[16:8] > 9'(hsv2argb_pkg::BYTE_MAX)) ?
               hsv2argb_pkg::BYTE_MAX : alp_scaled2[15:8];
   end

   always_comb begin
      k43        = 13'(k2_ff) * 13'(hsv2argb_pkg::SECTOR_RECIP);
      q6         = k43[12:8];
      sec_raw3   = k2_ff - 7'(q6) * 7'(hsv2argb_pkg::SECTOR_COUNT);
      sector3_in = hsv2argb_pkg::sector_type'(sec_raw3[2:0]);
      // odd sectors run down from the sector's end
      t3 = k2_ff[0] ? (11'(hsv2argb_pkg::SECTOR_SPAN) - 11'(f2_ff)) : 11'(f2_ff);
      ct3_in = 29'(c2_ff) * 29'(t3);
   end

   always_comb begin
      x_prod4 = 58'(ct3_ff) * 58'(hsv2argb_pkg::X_RECIP);
      xq4_in  = x_prod4[55:38];
   end

   always_comb begin
      xr5   = ct4_ff - 29'(xq4_ff) * 29'(hsv2argb_pkg::SECTOR_SPAN);
      x5_in = xq4_ff + 18'(xr5 >= 29'(hsv2argb_pkg::SECTOR_SPAN));
   end

   always_comb begin
      cs6 = $signed({3'd0, c5_ff});
      xs6 = $signed({3'd0, x5_ff});
      ms6 = {m5_ff[19], m5_ff};
      unique case (sector5_ff)
         hsv2argb_pkg::SECTOR_RED_YELLOW: begin
            red6 = cs6 + ms6; green6 = xs6 + ms6; blue6 = ms6;
         end
         hsv2argb_pkg::SECTOR_YELLOW_GREEN: begin
            red6 = xs6 + ms6; green6 = cs6 + ms6; blue6 = ms6;
         end
         hsv2argb_pkg::SECTOR_GREEN_CYAN: begin
            red6 = ms6; green6 = cs6 + ms6; blue6 = xs6 + ms6;
         end
         hsv2argb_pkg::SECTOR_CYAN_BLUE: begin
            red6 = ms6; green6 = xs6 + ms6; blue6 = cs6 + ms6;
         end
         hsv2argb_pkg::SECTOR_BLUE_MAGENTA: begin
            red6 = xs6 + ms6; green6 = ms6; blue6 = cs6 + ms6;
         end
         default: begin
            red6 = cs6 + ms6; green6 = ms6; blue6 = xs6 + ms6;
         end
      endcase
      rb6 = hsv2argb_pkg::to_byte(red6);
      gb6 = hsv2argb_pkg::to_byte(green6);
      bb6 = hsv2argb_pkg::to_byte(blue6);
      if (byte_order_ff == hsv2argb_pkg::BYTE_ORDER_RGBA) begin
         pixel6_in = {rb6, gb6, bb6, ab5_ff};
      end else begin
         pixel6_in = {ab5_ff, rb6, gb6, bb6};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         hue1_ff  <= req_hue_sixteenths;
         kest1_ff <= hue_prod_in[32:26];
         c1_ff    <= c1_in;
         val1_ff  <= req_brightness;
         alp1_ff  <= req_opacity;

         k2_ff  <= k2_in;
         f2_ff  <= f2_in;
         c2_ff  <= c1_ff;
         m2_ff  <= m2_in;
         ab2_ff <= ab2_in;

         sector3_ff <= sector3_in;
         ct3_ff     <= ct3_in;
         c3_ff      <= c2_ff;
         m3_ff      <= m2_ff;
         ab3_ff     <= ab2_ff;

         sector4_ff <= sector3_ff;
         ct4_ff     <= ct3_ff;
         xq4_ff     <= xq4_in;
         c4_ff      <= c3_ff;
         m4_ff      <= m3_ff;
         ab4_ff     <= ab3_ff;

         sector5_ff <= sector4_ff;
         x5_ff      <= x5_in;
         c5_ff      <= c4_ff;
         m5_ff      <= m4_ff;
         ab5_ff     <= ab4_ff;

         pixel6_ff <= pixel6_in;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/hsv2argb_checker.sv @@
// hsv2argb_checker: port-level assertions for hsv_to_argb_pixel_core
// and the bind that attaches them; depends on the core's port list
`default_nettype none

module hsv2argb_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_packed_pixel,
   input wire logic        csr_ready
);

   // stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_packed_pixel))
      else $error("stalled result transaction changed");

   // a stalled output blocks new transactions
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input accepted while output stalled");

   // an empty output slot keeps the pipeline moving
   a_empty_moves: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready && csr_ready)
      else $error("pipeline stalled with empty output");

   // nothing leaves the pipeline right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind hsv_to_argb_pixel_core hsv2argb_checker u_hsv2argb_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_packed_pixel (rsp_packed_pixel),
   .csr_ready        (csr_ready)
);

`default_nettype wire

@@ test/hsv_to_argb_pixel_core_tb.sv @@
// hsv_to_argb_pixel_core_tb: self-checking bench for the hsv to packed pixel core,
// random handshake gaps on both channels and both byte orders checked per pixel
// depends on hsv2argb_pkg and hsv_to_argb_pixel_core
`default_nettype none

module hsv_to_argb_pixel_core_tb;

   localparam longint HUE_FULL     = 5760;
   localparam longint SPAN         = longint'(hsv2argb_pkg::SECTOR_SPAN);
   localparam int     STALL_LIMIT  = 2000;
   localparam int     REPORT_LIMIT = 10;
   localparam int     RANDOM_ITEMS = 200;

   typedef struct packed {
      logic [15:0] hue_sixteenths;
      logic [8:0]  saturation;
      logic [8:0]  brightness;
      logic [8:0]  opacity;
   } pixel_in_type;

   class pixel_ledger;
      logic [31:0]                  pending_pixels[$];
      hsv2argb_pkg::byte_order_type order;
      int                           failures;

      function new();
         order    = hsv2argb_pkg::BYTE_ORDER_ARGB;
         failures = 0;
      endfunction

      function logic [7:0] level_to_byte(longint level);
         longint q;
         if (level <= 0) begin
            return 8'd0;
         end
         q = (level * 255) >>> 16;
         return (q > 255) ? 8'd255 : q[7:0];
      endfunction

      function logic [31:0] predict_pixel(pixel_in_type p);
         longint     hue, idx, pos, chroma, second, offset, red, green, blue, aq;
         hsv2argb_pkg::sector_type sec;
         logic [7:0] rb, gb, bb, ab;
         hue    = longint'(p.hue_sixteenths) % HUE_FULL;
         idx    = hue / SPAN;
         sec    = hsv2argb_pkg::sector_type'(idx);
         pos    = hue - idx * SPAN;
         if (idx % 2 == 1) begin
            pos = SPAN - pos;
         end
         chroma = longint'(p.brightness) * longint'(p.saturation);
         second = (chroma * pos) / SPAN;
         offset = longint'(p.brightness) * 256 - chroma;
         red    = 0;
         green  = 0;
         blue   = 0;
         case (sec)
            hsv2argb_pkg::SECTOR_RED_YELLOW: begin
               red = chroma; green = second;
            end
            hsv2argb_pkg::SECTOR_YELLOW_GREEN: begin
               red = second; green = chroma;
            end
            hsv2argb_pkg::SECTOR_GREEN_CYAN: begin
               green = chroma; blue = second;
            end
            hsv2argb_pkg::SECTOR_CYAN_BLUE: begin
               green = second; blue = chroma;
            end
            hsv2argb_pkg::SECTOR_BLUE_MAGENTA: begin
               red = second; blue = chroma;
            end
            default: begin
               red = chroma; blue = second;
            end
         endcase
         rb = level_to_byte(red + offset);
         gb = level_to_byte(green + offset);
         bb = level_to_byte(blue + offset);
         aq = (longint'(p.opacity) * 255) >>> 8;
         ab = (aq > 255) ? 8'd255 : aq[7:0];
         if (order == hsv2argb_pkg::BYTE_ORDER_RGBA) begin
            return {rb, gb, bb, ab};
         end
         return {ab, rb, gb, bb};
      endfunction

      function void set_order(hsv2argb_pkg::byte_order_type o);
         order = o;
      endfunction

      function void record_request(pixel_in_type p);
         pending_pixels.insert(pending_pixels.size(), predict_pixel(p));
      endfunction

      function void compare_pixel(logic [31:0] actual);
         logic [31:0] wanted;
         if (pending_pixels.size() == 0) begin
            if (failures < REPORT_LIMIT) begin
               $display("unexpected pixel %08h with nothing pending", actual);
            end
            failures++;
            return;
         end
         wanted = pending_pixels.pop_front();
         if (actual !== wanted) begin
            if (failures < REPORT_LIMIT) begin
               $display("packed_pixel mismatch: expected %08h got %08h", wanted, actual);
            end
            failures++;
         end
      endfunction

      function int pending();
         return pending_pixels.size();
      endfunction

      function void flag_leftovers();
         if (pending_pixels.size() != 0) begin
            $display("%0d pixels never returned", pending_pixels.size());
            failures += pending_pixels.size();
         end
      endfunction
   endclass

   logic        clock;
   logic        reset              = 1'b1;
   logic        req_valid          = 1'b0;
   logic        req_ready;
   logic [15:0] req_hue_sixteenths = '0;
   logic [8:0]  req_saturation     = '0;
   logic [8:0]  req_brightness     = '0;
   logic [8:0]  req_opacity        = '0;
   logic        rsp_valid;
   logic        rsp_ready          = 1'b0;
   logic [31:0] rsp_packed_pixel;
   logic        csr_valid          = 1'b0;
   logic        csr_ready;
   logic [0:0]  csr_byte_order     = '0;

   pixel_ledger board = new();
   bit          steady = 1'b0;
   int          idle_cycles = 0;

   pixel_in_type directed_set[19] = '{
      '{16'd0,     9'd256, 9'd256, 9'd256},
      '{16'd959,   9'd256, 9'd256, 9'd255},
      '{16'd960,   9'd256, 9'd256, 9'd256},
      '{16'd1920,  9'd256, 9'd256, 9'd0},
      '{16'd2880,  9'd256, 9'd256, 9'd1},
      '{16'd3840,  9'd256, 9'd256, 9'd128},
      '{16'd4800,  9'd256, 9'd256, 9'd256},
      '{16'd5759,  9'd256, 9'd256, 9'd256},
      '{16'd5760,  9'd256, 9'd256, 9'd256},
      '{16'd65535, 9'd511, 9'd511, 9'd511},
      '{16'd480,   9'd0,   9'd256, 9'd256},
      '{16'd480,   9'd256, 9'd0,   9'd1},
      '{16'd1440,  9'd511, 9'd256, 9'd256},
      '{16'd2400,  9'd256, 9'd511, 9'd256},
      '{16'd3360,  9'd511, 9'd511, 9'd0},
      '{16'd4320,  9'd128, 9'd200, 9'd300},
      '{16'd5280,  9'd1,   9'd1,   9'd511},
      '{16'd11620, 9'd200, 9'd100, 9'd257},
      '{16'd57600, 9'd255, 9'd255, 9'd255}
   };

   hsv_to_argb_pixel_core dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_hue_sixteenths (req_hue_sixteenths),
      .req_saturation     (req_saturation),
      .req_brightness     (req_brightness),
      .req_opacity        (req_opacity),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_packed_pixel   (rsp_packed_pixel),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_byte_order     (csr_byte_order)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int draw_gap();
      return steady ? 0 : int'($urandom_range(0, 5));
   endfunction

   function automatic logic [8:0] random_fraction();
      int sel;
      sel = $urandom_range(0, 9);
      case (sel)
         0: return 9'($urandom_range(0, 511));
         1: return 9'($urandom_range(257, 511));
         2: return (($urandom_range(0, 1) == 0) ? 9'd0 : 9'd256);
         default: return 9'($urandom_range(0, 256));
      endcase
   endfunction

   function automatic pixel_in_type random_pixel();
      pixel_in_type p;
      int           sel;
      sel = $urandom_range(0, 3);
      case (sel)
         0: p.hue_sixteenths = 16'($urandom);
         1: p.hue_sixteenths = 16'($urandom_range(0, 6) * 960 + $urandom_range(0, 2)) - 16'd1;
         default: p.hue_sixteenths = 16'($urandom_range(0, 5759));
      endcase
      p.saturation = random_fraction();
      p.brightness = random_fraction();
      p.opacity    = random_fraction();
      return p;
   endfunction

   task automatic send_pixel(input pixel_in_type p);
      int gap;
      gap = draw_gap();
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid          <= 1'b1;
      req_hue_sixteenths <= p.hue_sixteenths;
      req_saturation     <= p.saturation;
      req_brightness     <= p.brightness;
      req_opacity        <= p.opacity;
      do @(posedge clock); while (!req_ready);
      board.record_request(p);
   endtask

   task automatic write_order(input hsv2argb_pkg::byte_order_type o);
      @(negedge clock);
      csr_valid      <= 1'b1;
      csr_byte_order <= o;
      do @(posedge clock); while (!csr_ready);
      board.set_order(o);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_until_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic send_random_run(input int count);
      for (int i = 0; i < count; i++) begin
         if (i % 40 == 0) begin
            steady = ($urandom_range(0, 2) == 0);
         end
         send_pixel(random_pixel());
      end
   endtask

   // result side: random stall before each pixel
   initial begin
      int stall;
      wait (!reset);
      forever begin
         stall = draw_gap();
         repeat (stall) begin
            @(negedge clock);
            rsp_ready <= 1'b0;
         end
         @(negedge clock);
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         board.compare_pixel(rsp_packed_pixel);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_order(hsv2argb_pkg::BYTE_ORDER_RGBA);
      foreach (directed_set[i]) begin
         send_pixel(directed_set[i]);
      end
      wait_until_drained();

      write_order(hsv2argb_pkg::BYTE_ORDER_ARGB);
      foreach (directed_set[i]) begin
         if (i < 4) begin
            send_pixel(directed_set[i]);
         end
      end
      send_random_run(RANDOM_ITEMS);
      wait_until_drained();

      write_order(hsv2argb_pkg::BYTE_ORDER_RGBA);
      send_random_run(RANDOM_ITEMS);
      wait_until_drained();

      write_order(hsv2argb_pkg::BYTE_ORDER_ARGB);
      send_random_run(RANDOM_ITEMS);
      wait_until_drained();

      repeat (16) @(posedge clock);
      board.flag_leftovers();
      if (board.failures == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
